/* design/gbte_pkg.sv */
// ----------------------------------------------------------------------------
// Gap buffer text editor package
// Shared constants, command and status codes, and controller states.
// ----------------------------------------------------------------------------
package gbte_pkg;

  // Default text store size in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 4096;

  // Fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CHAR_W   = 21;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  // Printable range [CHAR_MIN, CHAR_LIMIT) and the newline byte
  localparam logic [CHAR_W-1:0] CHAR_MIN   = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CHAR_LIMIT = CHAR_W'(128);
  localparam logic [BYTE_W-1:0] NEWLINE    = 8'h0A;

  // Key event codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LEFT      = 3'd0,
    CMD_RIGHT     = 3'd1,
    CMD_BACKSPACE = 3'd2,
    CMD_ENTER     = 3'd3,
    CMD_CHAR      = 3'd4,
    CMD_READ      = 3'd5
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_EDIT,
    S_READ,
    S_FINISH
  } state_e;

endpackage

/* design/gap_buffer_text_editor.sv */
// ----------------------------------------------------------------------------
// Gap buffer text editor
// Text store kept as a gap buffer with an edit cursor, driven by key events.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake         | Payload
//  ---------+-------------------+-----------------------------------------------
//  event in | start / busy      | cmd_i, code_point_i, read_position_i
//  result   | done_o (1 cycle)  | read_byte_o, cursor_position_o,
//           |                   | text_length_o, status_o
//
//  Cursor moves and ignored characters go from idle straight to finish; reads
//  pass through a read state. Edits first move the gap to the cursor one byte
//  per cycle over the single RAM write port, then insert or delete the byte.
//  busy stays high from the accepting edge until the result strobe cycle, in
//  which a new event may already be accepted.
//  Reset clears the gap to the whole store and the cursor to 0; the store
//  content is left as is. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor
  import gbte_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [CMD_W-1:0]                  cmd_i,
  input  logic [CHAR_W-1:0]                 code_point_i,
  input  logic [$clog2(BUFFER_BYTES)-1:0]   read_position_i,
  output logic                              done_o,
  output logic [BYTE_W-1:0]                 read_byte_o,
  output logic [$clog2(BUFFER_BYTES)-1:0]   cursor_position_o,
  output logic [$clog2(BUFFER_BYTES+1)-1:0] text_length_o,
  output logic [STATUS_W-1:0]               status_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned LW = $clog2(BUFFER_BYTES + 1);
  localparam logic [LW-1:0] BUF_LEN    = LW'(BUFFER_BYTES);
  localparam logic [AW-1:0] CURSOR_MAX = AW'(BUFFER_BYTES - 1);

  state_e             state_q, state_d;
  cmd_e               cmd_q;
  status_e            status_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [LW-1:0]      gf_q, ge_q, target_q;
  logic [AW-1:0]      cursor_q;
  logic [AW-1:0]      rd_addr_q;
  logic               rd_hit_q;
  logic               pend_q;
  logic [AW-1:0]      waddr_q;
  logic [BYTE_W-1:0]  rbyte_q;
  logic               done_q;

  // RAM port signals
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

  // Shared datapath terms
  logic [LW-1:0]      text_len;
  logic [LW-1:0]      gap_size;
  logic [LW-1:0]      rpos_ext, cursor_ext;
  logic               char_ok;
  logic               move_fwd, move_act;
  logic               ins_ok;
  logic [AW-1:0]      cursor_inc, cursor_dec;

  assign gap_size   = ge_q - gf_q;
  assign text_len   = BUF_LEN - gap_size;
  assign rpos_ext   = LW'(read_position_i);
  assign cursor_ext = LW'(cursor_q);
  assign char_ok    = (code_point_i >= CHAR_MIN) && (code_point_i < CHAR_LIMIT);
  assign move_act   = (gf_q != target_q);
  assign move_fwd   = (target_q > gf_q);
  assign ins_ok     = (gf_q != ge_q);
  assign cursor_inc = (cursor_q == CURSOR_MAX) ? cursor_q : cursor_q + 1'b1;
  assign cursor_dec = (cursor_q == '0) ? cursor_q : cursor_q - 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_e'(cmd_i))
            CMD_BACKSPACE, CMD_ENTER: state_d = S_MOVE;
            CMD_CHAR:                 state_d = char_ok ? S_MOVE : S_FINISH;
            CMD_READ:                 state_d = S_READ;
            default:                  state_d = S_FINISH;
          endcase
        end
      end
      S_MOVE:   state_d = move_act ? S_MOVE : S_EDIT;
      S_EDIT:   state_d = S_FINISH;
      S_READ:   state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs and RAM control
  always_comb begin
    busy      = (state_q != S_IDLE);
    ram_raddr = rd_addr_q;
    if (state_q == S_MOVE) begin
      ram_raddr = move_fwd ? ge_q[AW-1:0] : AW'(gf_q - 1'b1);
    end
    // a pending gap-move write has priority over an insert
    ram_we    = pend_q || ((state_q == S_EDIT) && (cmd_q != CMD_BACKSPACE) && ins_ok);
    ram_waddr = pend_q ? waddr_q : gf_q[AW-1:0];
    ram_wdata = pend_q ? ram_rdata : byte_q;
  end

  // Control and gap registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gf_q     <= '0;
      ge_q     <= BUF_LEN;
      cursor_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FINISH);
      pend_q  <= 1'b0;
      unique case (state_q)
        S_MOVE: begin
          // one byte per cycle; the write lands in the next cycle
          if (move_act) begin
            pend_q <= 1'b1;
            if (move_fwd) begin
              gf_q <= gf_q + 1'b1;
              ge_q <= ge_q + 1'b1;
            end else begin
              gf_q <= gf_q - 1'b1;
              ge_q <= ge_q - 1'b1;
            end
          end
        end
        S_EDIT: begin
          if (cmd_q == CMD_BACKSPACE) begin
            if (gf_q != '0) gf_q <= gf_q - 1'b1;
          end else if (ins_ok) begin
            gf_q <= gf_q + 1'b1;
          end
        end
        S_FINISH: begin
          unique case (cmd_q)
            CMD_LEFT, CMD_BACKSPACE: cursor_q <= cursor_dec;
            CMD_RIGHT:               cursor_q <= cursor_inc;
            CMD_ENTER, CMD_CHAR: begin
              if (status_q == ST_DONE) cursor_q <= cursor_inc;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Event payload and result registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_q     <= cmd_e'(cmd_i);
          byte_q    <= (cmd_e'(cmd_i) == CMD_ENTER) ? NEWLINE : code_point_i[BYTE_W-1:0];
          status_q  <= ((cmd_e'(cmd_i) == CMD_CHAR) && !char_ok) ? ST_IGNORED : ST_DONE;
          // gap goes to the cursor, clamped to the text end
          target_q  <= (cursor_ext > text_len) ? text_len : cursor_ext;
          rd_hit_q  <= (rpos_ext < text_len);
          rd_addr_q <= (rpos_ext < gf_q) ? read_position_i : AW'(rpos_ext + gap_size);
        end
      end
      S_MOVE: begin
        waddr_q <= move_fwd ? gf_q[AW-1:0] : AW'(ge_q - 1'b1);
      end
      S_EDIT: begin
        if ((cmd_q != CMD_BACKSPACE) && !ins_ok) status_q <= ST_FULL;
      end
      S_FINISH: begin
        rbyte_q <= ((cmd_q == CMD_READ) && rd_hit_q) ? ram_rdata : '0;
      end
      default: ;
    endcase
  end

  // Text store
  gbte_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result ports
  assign done_o            = done_q;
  assign read_byte_o       = rbyte_q;
  assign cursor_position_o = cursor_q;
  assign text_length_o     = text_len;
  assign status_o          = status_q;

endmodule

/* design/gbte_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module gbte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gbte_checker.sv */
// ----------------------------------------------------------------------------
// Gap buffer text editor port checker
// Checks result strobe timing and full-buffer reporting at the top level.
// ----------------------------------------------------------------------------
module gbte_checker
  import gbte_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic [$clog2(BUFFER_BYTES+1)-1:0] text_length_o,
  input logic [STATUS_W-1:0]               status_o
);

  localparam logic [$clog2(BUFFER_BYTES+1)-1:0] FULL_LEN =
    ($clog2(BUFFER_BYTES+1))'(BUFFER_BYTES);

  // Every accepted transaction raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  // The result strobe comes exactly when busy drops
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // A result is never shown while busy, and strobes never run back to back
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy ##1 !done_o)
    else $error("result strobe overlaps busy or repeats");

  // A dropped insert only happens with the store full
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> text_length_o == FULL_LEN)
    else $error("insert dropped while the store had room");

endmodule

bind gap_buffer_text_editor gbte_checker #(
  .BUFFER_BYTES (BUFFER_BYTES)
) u_gbte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .text_length_o (text_length_o),
  .status_o      (status_o)
);
